>>> rtl/mbx_pkg.sv
// ---------------------------------------------------------------------------
// mbx_pkg
// Types, byte codes and the postmark table shared by the mbox quoting block.
// ---------------------------------------------------------------------------
package mbx_pkg;

    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChGt      = 8'h3E;

    // Length of the postmark "From " and the most matched bytes ever flushed.
    localparam logic [2:0] PostLen  = 3'd5;
    localparam logic [2:0] PostKeep = 3'd4;

    localparam int CmdDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       letter_end;
    } out_item_t;

    // One classified item: the results it causes, in this order:
    // a '>' or '.' prefix, postmark bytes, the input byte, newlines, a bare marker.
    typedef struct packed {
        logic       pre_gt;
        logic       pre_dot;
        logic [2:0] post_n;
        logic       has_c;
        logic [7:0] c;
        logic [1:0] nl_cnt;
        logic       bare;
        logic       letter_end;
    } cmd_t;

    function automatic logic [7:0] pm_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h46;  // F
            3'd1:    b = 8'h72;  // r
            3'd2:    b = 8'h6F;  // o
            3'd3:    b = 8'h6D;  // m
            3'd4:    b = 8'h20;  // space
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/mbx_front.sv
// ---------------------------------------------------------------------------
// mbx_front
// Line tracker: classifies each accepted byte and emits at most one command word.
// ---------------------------------------------------------------------------
module mbx_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mbx_pkg::in_item_t item,
    output mbx_pkg::cmd_t     cmd,
    output logic              cmd_push
);

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_DOT   = 3'd1,
        MODE_POST  = 3'd2,
        MODE_MID   = 3'd3,
        MODE_DONE  = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [2:0] match_reg, match_next;
    logic       blank_reg, blank_next;

    logic [7:0] c;
    logic [2:0] match_plus;
    logic [2:0] keep_n;
    logic       pm_hit;
    logic       blank_eff;

    assign c          = item.data_byte;
    assign match_plus = match_reg + 3'd1;
    assign keep_n     = (match_reg > mbx_pkg::PostKeep) ? mbx_pkg::PostKeep : match_reg;
    assign pm_hit     = (match_reg < mbx_pkg::PostLen) && (c == mbx_pkg::pm_byte(match_reg));

    always_comb
    begin
        mode_next  = mode_reg;
        match_next = match_reg;
        blank_next = blank_reg;
        cmd        = '0;
        cmd.c      = c;
        cmd_push   = 1'b0;
        blank_eff  = 1'b0;
        if (accept)
        begin
            if (item.end_of_input)
            begin
                if (mode_reg != MODE_DONE)
                begin
                    // A pending dot or postmark makes a nonblank line.
                    blank_eff      = blank_reg && (mode_reg != MODE_DOT) &&
                                     (mode_reg != MODE_POST);
                    cmd_push       = 1'b1;
                    cmd.pre_dot    = (mode_reg == MODE_DOT);
                    cmd.post_n     = (mode_reg == MODE_POST) ? keep_n : 3'd0;
                    cmd.nl_cnt     = {1'b0, mode_reg != MODE_START} + {1'b0, !blank_eff};
                    cmd.bare       = blank_eff;
                    cmd.letter_end = 1'b1;
                end
                mode_next  = MODE_START;
                match_next = 3'd0;
                blank_next = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_DONE:
                    begin
                    end
                    MODE_START:
                    begin
                        if (c == mbx_pkg::ChDot)
                        begin
                            mode_next = MODE_DOT;
                        end
                        else if (c == mbx_pkg::pm_byte(3'd0))
                        begin
                            mode_next  = MODE_POST;
                            match_next = 3'd1;
                        end
                        else
                        begin
                            cmd_push  = 1'b1;
                            cmd.has_c = 1'b1;
                            if (c == mbx_pkg::ChNewline)
                            begin
                                blank_next = 1'b1;
                            end
                            else
                            begin
                                mode_next  = MODE_MID;
                                blank_next = 1'b0;
                            end
                        end
                    end
                    MODE_DOT:
                    begin
                        cmd_push = 1'b1;
                        if (c == mbx_pkg::ChNewline)
                        begin
                            mode_next      = MODE_DONE;
                            cmd.bare       = blank_reg;
                            cmd.nl_cnt     = {1'b0, !blank_reg};
                            cmd.letter_end = 1'b1;
                        end
                        else
                        begin
                            mode_next   = MODE_MID;
                            blank_next  = 1'b0;
                            cmd.pre_dot = 1'b1;
                            cmd.has_c   = 1'b1;
                        end
                    end
                    MODE_POST:
                    begin
                        if (pm_hit)
                        begin
                            match_next = match_plus;
                            if (match_plus >= mbx_pkg::PostLen)
                            begin
                                cmd_push   = 1'b1;
                                cmd.pre_gt = 1'b1;
                                cmd.post_n = mbx_pkg::PostLen;
                                match_next = 3'd0;
                                mode_next  = MODE_MID;
                                blank_next = 1'b0;
                            end
                        end
                        else
                        begin
                            // Mismatch: write out what matched, then this byte.
                            cmd_push   = 1'b1;
                            cmd.post_n = keep_n;
                            cmd.has_c  = 1'b1;
                            mode_next  = (c == mbx_pkg::ChNewline) ? MODE_START : MODE_MID;
                            match_next = 3'd0;
                            blank_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        cmd_push  = 1'b1;
                        cmd.has_c = 1'b1;
                        mode_next = (c == mbx_pkg::ChNewline) ? MODE_START : MODE_MID;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            match_reg <= 3'd0;
            blank_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            match_reg <= match_next;
            blank_reg <= blank_next;
        end
    end

endmodule

>>> rtl/mbx_cmd_fifo.sv
// ---------------------------------------------------------------------------
// mbx_cmd_fifo
// Short command queue between the line tracker and the result sequencer.
// ---------------------------------------------------------------------------
module mbx_cmd_fifo
#(
    parameter int DEPTH = mbx_pkg::CmdDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbx_pkg::cmd_t push_cmd,
    input  logic          pop,
    output mbx_pkg::cmd_t head,
    output logic          head_valid,
    output logic          full
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    mbx_pkg::cmd_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/mbx_back.sv
// ---------------------------------------------------------------------------
// mbx_back
// Result sequencer: expands the head command into beats into a registered output
// stage, one per cycle while that stage is empty or being popped.
// ---------------------------------------------------------------------------
module mbx_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbx_pkg::cmd_t      head,
    input  logic               head_valid,
    output logic               head_pop,
    output mbx_pkg::out_item_t result,
    output logic               empty,
    input  logic               pop
);

    logic [2:0]         idx_reg;
    logic               out_valid_reg;
    mbx_pkg::out_item_t out_reg;

    logic [3:0]         idx4;
    logic [3:0]         b0, b1, b2, b3, total;
    logic               can_load;
    logic               emit;
    mbx_pkg::out_item_t beat;

    assign idx4  = {1'b0, idx_reg};
    assign b0    = {3'd0, head.pre_gt | head.pre_dot};
    assign b1    = b0 + {1'b0, head.post_n};
    assign b2    = b1 + {3'd0, head.has_c};
    assign b3    = b2 + {2'd0, head.nl_cnt};
    assign total = b3 + {3'd0, head.bare};

    always_comb
    begin
        beat            = '0;
        beat.byte_valid = 1'b1;
        if (idx4 < b0)
        begin
            beat.out_byte = head.pre_gt ? mbx_pkg::ChGt : mbx_pkg::ChDot;
        end
        else if (idx4 < b1)
        begin
            beat.out_byte = mbx_pkg::pm_byte(3'(idx4 - b0));
        end
        else if (idx4 < b2)
        begin
            beat.out_byte = head.c;
        end
        else if (idx4 < b3)
        begin
            beat.out_byte = mbx_pkg::ChNewline;
        end
        else
        begin
            beat.byte_valid = 1'b0;
        end
        beat.last       = (idx4 == total - 4'd1);
        beat.letter_end = beat.last && head.letter_end;
    end

    assign can_load = !out_valid_reg || pop;
    assign emit     = head_valid && can_load;
    assign head_pop = emit && beat.last;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                out_valid_reg <= emit;
            end
            if (emit)
            begin
                idx_reg <= beat.last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

endmodule

>>> rtl/mbox_from_escape_dot_terminator.sv
// ---------------------------------------------------------------------------
// mbox_from_escape_dot_terminator
// Copies a letter in mbox form: quotes postmark lines, ends on a lone dot.
// ---------------------------------------------------------------------------
//  channel  | ports               | beat taken when
//  ---------+---------------------+----------------------
//  input    | item, push, full    | push high, full low
//  result   | result, pop, empty  | pop high, empty low
//
// The line tracker takes one byte per cycle while full is low, classifying it
// in that cycle. The sequencer writes one result beat per cycle unless the
// output stalls; the command queue absorbs items causing one to six beats.
// An item's results pass through the command queue, then the output register.
// full rises only when the command queue holds CMD_DEPTH commands.
// rst_n clears the line state, the queue and the output stage asynchronously.
// ---------------------------------------------------------------------------
module mbox_from_escape_dot_terminator
#(
    parameter int CMD_DEPTH = mbx_pkg::CmdDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mbx_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output mbx_pkg::out_item_t result
);

    logic          accept;
    mbx_pkg::cmd_t cmd;
    logic          cmd_push;
    mbx_pkg::cmd_t head;
    logic          head_valid;
    logic          head_pop;

    assign accept = push && !full;

    mbx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd      (cmd),
        .cmd_push (cmd_push)
    );

    mbx_cmd_fifo
    #(
        .DEPTH (CMD_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .pop        (head_pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    mbx_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    // A command is only written for a beat actually taken.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> accept)
        else $error("command written without an accepted input beat");

    // The sequencer never retires a command the queue does not hold.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid)
        else $error("command queue popped while empty");

    // The letter end always closes its item's results.
    a_letter_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.letter_end) |-> result.last)
        else $error("letter end on a beat that is not last");

    // A bare marker only ever stands as the closing beat of a letter.
    a_bare_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.last && result.letter_end))
        else $error("bare marker that does not close the letter");

endmodule

>>> tb/sv/mbox_from_escape_dot_terminator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mbox_from_escape_dot_terminator_tb
// Drives letters through the mbox quoting block and checks every result beat
// against a line tracker kept in the bench. Directed letters cover byte
// extremes, postmark quoting, dot lines and the flush at end of input.
// Random letters follow, mixed with noise. Both sides idle at random, and one
// pass stalls the output long enough for the block to refuse input.
// ---------------------------------------------------------------------------
module mbox_from_escape_dot_terminator_tb;

    typedef enum logic [2:0] {
        LM_START = 3'd0,
        LM_DOT   = 3'd1,
        LM_POST  = 3'd2,
        LM_MID   = 3'd3,
        LM_DONE  = 3'd4
    } line_mode_t;

    localparam logic [39:0] POSTMARK  = "From ";
    localparam int          IDLE_PCT  = 38;
    localparam int          LIVE_GOAL = 130;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    mbx_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    mbx_pkg::out_item_t result;

    // Line tracker state mirrored from the block.
    line_mode_t line_mode;
    logic [2:0] post_hits;
    logic       last_blank;

    mbx_pkg::out_item_t step_beats[$];
    mbx_pkg::out_item_t copy_q[$];

    logic no_idle;
    int   hold_req;
    int   hold_left;
    int   mismatches;
    int   live_items;
    int   beats_checked;
    int   letters_closed;
    int   full_cycles;

    mbox_from_escape_dot_terminator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] postmark_at(input int idx);
        return POSTMARK[39 - 8 * idx -: 8];
    endfunction

    function automatic void emit_copy(input logic valid, input logic [7:0] b);
        mbx_pkg::out_item_t r;
        r.out_byte   = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.last       = 1'b0;
        r.letter_end = 1'b0;
        step_beats.push_back(r);
    endfunction

    // The final beat of an item carries last, and letter_end when the letter closes.
    function automatic void close_step(input logic done);
        mbx_pkg::out_item_t r;
        if (step_beats.size() > 0)
        begin
            r = step_beats.pop_back();
            r.last       = 1'b1;
            r.letter_end = done;
            step_beats.push_back(r);
        end
        while (step_beats.size() > 0)
            copy_q.push_back(step_beats.pop_front());
    endfunction

    function automatic void emit_matched();
        int n;
        n = (post_hits < mbx_pkg::PostLen) ? int'(post_hits) : int'(mbx_pkg::PostKeep);
        for (int i = 0; i < n; i++)
            emit_copy(1'b1, postmark_at(i));
    endfunction

    function automatic void close_letter_copy();
        if (last_blank)
            emit_copy(1'b0, 8'h00);
        else
            emit_copy(1'b1, mbx_pkg::ChNewline);
        close_step(1'b1);
    endfunction

    function automatic void reset_tracker();
        line_mode  = LM_START;
        post_hits  = 3'd0;
        last_blank = 1'b0;
    endfunction

    function automatic void predict_copy(input mbx_pkg::in_item_t it);
        logic [7:0] c;
        c = it.data_byte;
        if (it.end_of_input)
        begin
            if (line_mode != LM_DONE)
            begin
                if (line_mode == LM_DOT)
                begin
                    emit_copy(1'b1, mbx_pkg::ChDot);
                    last_blank = 1'b0;
                end
                else if (line_mode == LM_POST)
                begin
                    emit_matched();
                    last_blank = 1'b0;
                end
                if (line_mode != LM_START)
                    emit_copy(1'b1, mbx_pkg::ChNewline);
                close_letter_copy();
            end
            reset_tracker();
            return;
        end
        case (line_mode)
            LM_DONE:
            begin
            end
            LM_START:
            begin
                if (c == mbx_pkg::ChDot)
                    line_mode = LM_DOT;
                else if (c == postmark_at(0))
                begin
                    post_hits = 3'd1;
                    line_mode = LM_POST;
                end
                else
                begin
                    if (c == mbx_pkg::ChNewline)
                        last_blank = 1'b1;
                    else
                    begin
                        line_mode  = LM_MID;
                        last_blank = 1'b0;
                    end
                    emit_copy(1'b1, c);
                end
                close_step(1'b0);
            end
            LM_DOT:
            begin
                if (c == mbx_pkg::ChNewline)
                begin
                    line_mode = LM_DONE;
                    close_letter_copy();
                end
                else
                begin
                    line_mode  = LM_MID;
                    last_blank = 1'b0;
                    emit_copy(1'b1, mbx_pkg::ChDot);
                    emit_copy(1'b1, c);
                    close_step(1'b0);
                end
            end
            LM_POST:
            begin
                if (post_hits < mbx_pkg::PostLen && c == postmark_at(post_hits))
                begin
                    post_hits = post_hits + 3'd1;
                    if (post_hits >= mbx_pkg::PostLen)
                    begin
                        emit_copy(1'b1, mbx_pkg::ChGt);
                        for (int i = 0; i < int'(mbx_pkg::PostLen); i++)
                            emit_copy(1'b1, postmark_at(i));
                        post_hits  = 3'd0;
                        line_mode  = LM_MID;
                        last_blank = 1'b0;
                    end
                end
                else
                begin
                    // Matching does not restart on this line once it fails.
                    emit_matched();
                    emit_copy(1'b1, c);
                    line_mode  = (c == mbx_pkg::ChNewline) ? LM_START : LM_MID;
                    post_hits  = 3'd0;
                    last_blank = 1'b0;
                end
                close_step(1'b0);
            end
            default:
            begin
                line_mode = (c == mbx_pkg::ChNewline) ? LM_START : LM_MID;
                emit_copy(1'b1, c);
                close_step(1'b0);
            end
        endcase
    endfunction

    // Offers one beat and holds it until the block takes it.
    task automatic send_beat(input logic [7:0] b, input logic eoi);
        int                gap;
        mbx_pkg::in_item_t it;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.data_byte    = b;
        it.end_of_input = eoi;
        item <= it;
        push <= 1'b1;
        do @(posedge clk); while (full);
        if (eoi || line_mode != LM_DONE)
            live_items++;
        predict_copy(it);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(99) < 15)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    task automatic send_random_bytes(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_beat(text_byte(), 1'b0);
    endtask

    task automatic send_postmark_prefix(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_beat(postmark_at(i), 1'b0);
    endtask

    // Stops offering and waits for every predicted beat to come out.
    task automatic drain_copy();
        push <= 1'b0;
        do @(posedge clk); while (copy_q.size() != 0);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_eoi();
        drain_copy();
    endtask

    task automatic test_postmark_quoting();
        send_text("From ");
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_text("Fr");
        send_beat(mbx_pkg::ChNewline, 1'b0);
        drain_copy();
    endtask

    task automatic test_dot_lines();
        send_text(".x");
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_beat(mbx_pkg::ChNewline, 1'b0);
        // Terminator right after a blank line closes with a bare marker.
        send_beat(mbx_pkg::ChDot, 1'b0);
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_text("z");
        send_eoi();
        drain_copy();
    endtask

    task automatic test_end_of_input_flush();
        send_beat(mbx_pkg::ChDot, 1'b0);
        send_eoi();
        send_text("Fro");
        send_eoi();
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_eoi();
        drain_copy();
    endtask

    task automatic send_random_letter();
        int lines;
        int i;
        lines = $urandom_range(1, 6);
        for (i = 0; i < lines; i++)
        begin
            case ($urandom_range(0, 9))
                0: ;
                1: send_text("From ");
                2:
                begin
                    send_postmark_prefix($urandom_range(1, 4));
                    send_beat(text_byte(), 1'b0);
                end
                3: send_beat(mbx_pkg::ChDot, 1'b0);
                4: send_text("..");
                default: ;
            endcase
            send_random_bytes($urandom_range(0, 6));
            send_beat(mbx_pkg::ChNewline, 1'b0);
        end
        case ($urandom_range(0, 3))
            0, 1:
            begin
                send_beat(mbx_pkg::ChDot, 1'b0);
                send_beat(mbx_pkg::ChNewline, 1'b0);
                send_random_bytes($urandom_range(0, 3));
            end
            2: ;
            default:
            begin
                if ($urandom_range(1))
                    send_beat(mbx_pkg::ChDot, 1'b0);
                else
                    send_postmark_prefix($urandom_range(1, 4));
            end
        endcase
        send_eoi();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_text("From the hills");
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_text(".a");
        send_beat(mbx_pkg::ChNewline, 1'b0);
        send_eoi();
        drain_copy();
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        int i;
        hold_req = 150;
        for (i = 0; i < 4; i++)
        begin
            send_text("From a");
            send_beat(mbx_pkg::ChNewline, 1'b0);
        end
        send_eoi();
        drain_copy();
    endtask

    task automatic test_random_letters();
        while (live_items < LIVE_GOAL)
        begin
            if ($urandom_range(99) < 80)
                send_random_letter();
            else
                repeat ($urandom_range(1, 5))
                    send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
            if ($urandom_range(9) == 0)
                drain_copy();
        end
        drain_copy();
    endtask

    // Result side: random idling, plus a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        mbx_pkg::out_item_t want;
        if (rst_n && push && full)
            full_cycles++;
        if (rst_n && pop && !empty)
        begin
            if (copy_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat byte=%h valid=%b last=%b end=%b",
                             $realtime, result.out_byte, result.byte_valid,
                             result.last, result.letter_end);
            end
            else
            begin
                want = copy_q.pop_front();
                beats_checked++;
                if (result.letter_end === 1'b1)
                    letters_closed++;
                if (result.out_byte !== want.out_byte
                    || result.byte_valid !== want.byte_valid
                    || result.last !== want.last
                    || result.letter_end !== want.letter_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: beat %0d exp %h/%b/%b/%b got %h/%b/%b/%b",
                                 $realtime, beats_checked, want.out_byte,
                                 want.byte_valid, want.last, want.letter_end,
                                 result.out_byte, result.byte_valid,
                                 result.last, result.letter_end);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        item           = '0;
        pop            = 1'b0;
        no_idle        = 1'b0;
        hold_req       = 0;
        hold_left      = 0;
        mismatches     = 0;
        live_items     = 0;
        beats_checked  = 0;
        letters_closed = 0;
        full_cycles    = 0;
        reset_tracker();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_extremes();
        test_postmark_quoting();
        test_dot_lines();
        test_end_of_input_flush();
        test_back_to_back();
        test_output_stall();
        test_random_letters();

        repeat (16) @(posedge clk);
        if (copy_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected beats never arrived", copy_q.size());
        end
        $display("Run covered %0d input beats and %0d result beats over %0d letters.",
                 live_items, beats_checked, letters_closed);
        $display("Input was refused for %0d cycles while the output stalled.",
                 full_cycles);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/mbx_pkg.sv
rtl/mbx_front.sv
rtl/mbx_cmd_fifo.sv
rtl/mbx_back.sv
rtl/mbox_from_escape_dot_terminator.sv
tb/sv/mbox_from_escape_dot_terminator_tb.sv
